// ===== sv/lclp_pkg.sv =====
`default_nettype none

package lclp_pkg;

   localparam int unsigned LED_COUNT = 3;
   localparam int unsigned PIN_COUNT = 3;

   localparam logic [7:0] CH_L       = 8'h4C;
   localparam logic [7:0] CH_E       = 8'h45;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_WS_LO   = 8'h01;
   localparam logic [7:0] CH_WS_HI   = 8'h20;

   typedef enum logic [1:0] {
      REPLY_OK        = 2'd0,
      REPLY_BAD_STATE = 2'd1,
      REPLY_BAD_INDEX = 2'd2,
      REPLY_BAD_FMT   = 2'd3
   } reply_type;

   typedef enum logic [11:0] {
      PH_L        = 12'b0000_0000_0001,
      PH_E        = 12'b0000_0000_0010,
      PH_D        = 12'b0000_0000_0100,
      PH_WS_EQ    = 12'b0000_0000_1000,
      PH_WS_IDX   = 12'b0000_0001_0000,
      PH_IDX      = 12'b0000_0010_0000,
      PH_WS_COMMA = 12'b0000_0100_0000,
      PH_WS_LVL   = 12'b0000_1000_0000,
      PH_LVL      = 12'b0001_0000_0000,
      PH_DONE     = 12'b0010_0000_0000,
      PH_BADFMT   = 12'b0100_0000_0000,
      PH_DEAD     = 12'b1000_0000_0000
   } phase_type;

   function automatic logic [7:0] dec_accum(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] digit;
      digit = b - CH_ZERO;
      return {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + digit;
   endfunction

endpackage

`default_nettype wire

// ===== sv/led_command_line_parser_core.sv =====
`default_nettype none
// An accepted byte is held in the input register until it is parsed; its reply beat,
// if any, is registered together with the parse and is presented on rsp_* from there.
// Throughput: one byte per cycle while rsp_stall does not hold back a pending reply beat.
// Reset (synchronous, active high): parser returns to the start of a line,
// accumulators clear, all LED pins low, no beats pending.

module led_command_line_parser_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_reply_code,
   output logic [lclp_pkg::PIN_COUNT-1:0] rsp_led_levels
);
   import lclp_pkg::*;

   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       out_vld_ff, out_vld_in;
   reply_type  out_code_ff, out_code_in;
   logic [PIN_COUNT-1:0] out_pins_ff;

   phase_type  phase_ff, phase_in;
   logic [7:0] idx_ff, idx_in;
   logic [7:0] lvl_ff, lvl_in;
   logic [PIN_COUNT-1:0] pins_ff, pins_in;

   logic go;
   logic is_digit, is_space;

   assign go        = in_vld_ff && (!out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !go;
   assign is_digit  = in_byte_ff inside {[CH_ZERO:CH_NINE]};
   assign is_space  = in_byte_ff inside {[CH_WS_LO:CH_WS_HI]};

   always_comb begin
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      lvl_in      = lvl_ff;
      pins_in     = pins_ff;
      out_vld_in  = 1'b0;
      out_code_in = REPLY_OK;
      if (in_byte_ff == CH_NL) begin
         phase_in = PH_L;
         idx_in   = '0;
         lvl_in   = '0;
         if (phase_ff == PH_WS_EQ || phase_ff == PH_BADFMT) begin
            out_vld_in  = 1'b1;
            out_code_in = REPLY_BAD_FMT;
         end else if (phase_ff == PH_LVL || phase_ff == PH_DONE) begin
            out_vld_in = 1'b1;
            if (idx_ff >= 8'(LED_COUNT)) begin
               out_code_in = REPLY_BAD_INDEX;
            end else if (lvl_ff > 8'd1) begin
               out_code_in = REPLY_BAD_STATE;
            end else begin
               for (int i = 0; i < PIN_COUNT; i++) begin
                  if (idx_ff == 8'(i)) pins_in[i] = (lvl_ff == 8'd0);
               end
            end
         end
      end else begin
         case (phase_ff)
            PH_L: phase_in = (in_byte_ff == CH_L) ? PH_E : PH_DEAD;
            PH_E: phase_in = (in_byte_ff == CH_E) ? PH_D : PH_DEAD;
            PH_D: phase_in = (in_byte_ff == CH_D) ? PH_WS_EQ : PH_DEAD;
            PH_WS_EQ: begin
               if (in_byte_ff == CH_EQ) phase_in = PH_WS_IDX;
               else if (!is_space) phase_in = PH_BADFMT;
            end
            PH_WS_IDX: begin
               if (is_digit) begin
                  idx_in   = dec_accum(8'd0, in_byte_ff);
                  phase_in = PH_IDX;
               end else if (!is_space) phase_in = PH_DEAD;
            end
            PH_IDX: begin
               if (is_digit) idx_in = dec_accum(idx_ff, in_byte_ff);
               else if (in_byte_ff == CH_COMMA) phase_in = PH_WS_LVL;
               else if (is_space) phase_in = PH_WS_COMMA;
               else phase_in = PH_DEAD;
            end
            PH_WS_COMMA: begin
               if (in_byte_ff == CH_COMMA) phase_in = PH_WS_LVL;
               else if (!is_space) phase_in = PH_DEAD;
            end
            PH_WS_LVL: begin
               if (is_digit) begin
                  lvl_in   = dec_accum(8'd0, in_byte_ff);
                  phase_in = PH_LVL;
               end else if (!is_space) phase_in = PH_DEAD;
            end
            PH_LVL: begin
               if (is_digit) lvl_in = dec_accum(lvl_ff, in_byte_ff);
               else phase_in = PH_DONE;
            end
            PH_DONE, PH_BADFMT, PH_DEAD: phase_in = phase_ff;
            default: phase_in = PH_DEAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_L;
         idx_ff     <= '0;
         lvl_ff     <= '0;
         pins_ff    <= '0;
      end else begin
         if (!req_stall) begin
            in_vld_ff <= req_valid;
         end
         if (go) begin
            phase_ff   <= phase_in;
            idx_ff     <= idx_in;
            lvl_ff     <= lvl_in;
            pins_ff    <= pins_in;
            out_vld_ff <= out_vld_in;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
      if (go && out_vld_in) begin
         out_code_ff <= out_code_in;
         out_pins_ff <= pins_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_reply_code = out_code_ff;
   assign rsp_led_levels = out_pins_ff;

endmodule

`default_nettype wire

// ===== tb/led_command_line_parser_core_test.sv =====
`default_nettype none

module led_command_line_parser_core_test;
   import lclp_pkg::*;

   localparam int ITEM_TARGET    = 1500;
   localparam int IDLE_LIMIT     = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AT_BEAT   = 30;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_REPORTED   = 10;

   typedef struct packed {
      reply_type  code;
      logic [2:0] leds;
   } led_reply_type;

   typedef struct {
      string         text;
      bit            typed;
      bit            replies;
      led_reply_type reply;
   } line_case_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_reply_code;
   logic [PIN_COUNT-1:0] rsp_led_levels;

   // parser model state
   phase_type  phase = PH_L;
   logic [7:0] index_sum = 8'h00;
   logic [7:0] level_sum = 8'h00;
   logic [2:0] pins = 3'b000;

   led_reply_type due_replies[$];
   line_case_type line_cases[$];
   logic [7:0] line_bytes[$];
   int         bytes_sent = 0;
   int         mismatch_count = 0;
   int         idle_cycles = 0;

   led_command_line_parser_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reply_code (rsp_reply_code),
      .rsp_led_levels (rsp_led_levels)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit is_blank(input logic [7:0] b);
      return b >= CH_WS_LO && b <= CH_WS_HI;
   endfunction

   function automatic bit is_digit(input logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
   endfunction

   task automatic parse_byte(input logic [7:0] b, output bit replied,
                             output led_reply_type r);
      replied = 1'b0;
      r.code = REPLY_OK;
      r.leds = pins;
      if (b == CH_NL) begin
         case (phase)
            PH_WS_EQ, PH_BADFMT: begin
               replied = 1'b1;
               r.code = REPLY_BAD_FMT;
            end
            PH_LVL, PH_DONE: begin
               replied = 1'b1;
               if (index_sum >= LED_COUNT) r.code = REPLY_BAD_INDEX;
               else if (level_sum > 8'd1) r.code = REPLY_BAD_STATE;
               else if (index_sum < PIN_COUNT) pins[index_sum] = (level_sum == 8'd0);
            end
            default: ;
         endcase
         r.leds = pins;
         phase = PH_L;
         index_sum = 8'h00;
         level_sum = 8'h00;
      end else begin
         case (phase)
            PH_L: phase = (b == CH_L) ? PH_E : PH_DEAD;
            PH_E: phase = (b == CH_E) ? PH_D : PH_DEAD;
            PH_D: phase = (b == CH_D) ? PH_WS_EQ : PH_DEAD;
            PH_WS_EQ: begin
               if (b == CH_EQ) phase = PH_WS_IDX;
               else if (!is_blank(b)) phase = PH_BADFMT;
            end
            PH_WS_IDX: begin
               if (is_digit(b)) begin
                  index_sum = b - CH_ZERO;
                  phase = PH_IDX;
               end else if (!is_blank(b)) phase = PH_DEAD;
            end
            PH_IDX: begin
               if (is_digit(b)) index_sum = index_sum * 8'd10 + (b - CH_ZERO);
               else if (b == CH_COMMA) phase = PH_WS_LVL;
               else if (is_blank(b)) phase = PH_WS_COMMA;
               else phase = PH_DEAD;
            end
            PH_WS_COMMA: begin
               if (b == CH_COMMA) phase = PH_WS_LVL;
               else if (!is_blank(b)) phase = PH_DEAD;
            end
            PH_WS_LVL: begin
               if (is_digit(b)) begin
                  level_sum = b - CH_ZERO;
                  phase = PH_LVL;
               end else if (!is_blank(b)) phase = PH_DEAD;
            end
            PH_LVL: begin
               if (is_digit(b)) level_sum = level_sum * 8'd10 + (b - CH_ZERO);
               else phase = PH_DONE;
            end
            PH_DONE, PH_BADFMT, PH_DEAD: ;
            default: phase = PH_DEAD;
         endcase
      end
   endtask

   task automatic add_case(input string text, input bit typed, input bit replies,
                           input reply_type code, input logic [2:0] leds);
      line_case_type c;
      c.text = text;
      c.typed = typed;
      c.replies = replies;
      c.reply.code = code;
      c.reply.leds = leds;
      line_cases.push_back(c);
   endtask

   // '^' stands for byte 0, '_' for byte 1, '~' for byte 255
   task automatic load_text(input string s);
      logic [7:0] c;
      line_bytes.delete();
      for (int i = 0; i < s.len(); i++) begin
         c = s[i];
         if (c == "^") c = 8'h00;
         else if (c == "_") c = 8'h01;
         else if (c == "~") c = 8'hFF;
         line_bytes.push_back(c);
      end
   endtask

   task automatic add_blanks();
      int n;
      logic [7:0] b;
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) begin
         b = 8'($urandom_range(1, 32));
         if (b == CH_NL) b = CH_WS_HI;
         line_bytes.push_back(b);
      end
   endtask

   task automatic add_number(input int top);
      int n;
      if ($urandom_range(0, 3) != 0) begin
         line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, top)));
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) line_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
   endtask

   task automatic make_random_line();
      int kind;
      int n;
      int pos;
      logic [7:0] b;
      line_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         n = $urandom_range(0, 12);
         repeat (n) line_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         line_bytes.push_back(CH_L);
         line_bytes.push_back(CH_E);
         line_bytes.push_back(CH_D);
         add_blanks();
         line_bytes.push_back(CH_EQ);
         add_blanks();
         add_number(3);
         add_blanks();
         line_bytes.push_back(CH_COMMA);
         add_blanks();
         add_number(2);
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == CH_NL) b = 8'h00;
               line_bytes.push_back(b);
            end
         end
         pos = $urandom_range(0, line_bytes.size() - 1);
         if (kind == 1) line_bytes[pos] = 8'($urandom_range(0, 255));
         else if (kind == 2) line_bytes[pos] = 8'h00;
         else if (kind == 3) line_bytes.delete(pos);
      end
      line_bytes.push_back(CH_NL);
   endtask

   task automatic send_line(input bit steady, input bit typed, input bit typed_replies,
                            input led_reply_type typed_reply);
      int gap;
      bit got;
      led_reply_type r;
      for (int i = 0; i < line_bytes.size(); i++) begin
         req_valid <= 1'b1;
         req_rx_byte <= line_bytes[i];
         do @(posedge clock); while (req_stall);
         parse_byte(line_bytes[i], got, r);
         if (typed && i == line_bytes.size() - 1) begin
            if (typed_replies) due_replies.push_back(typed_reply);
         end else if (got) begin
            due_replies.push_back(r);
         end
         bytes_sent++;
         gap = steady ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      led_reply_type none;
      none = '{REPLY_OK, 3'b000};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_case("LED=0,0\n",            1, 1, REPLY_OK,        3'b001);
      add_case("LED _=_ 2\t, 0\n",     1, 1, REPLY_OK,        3'b101);
      add_case("LED=1,1\n",            1, 1, REPLY_OK,        3'b101);
      add_case("LED=0,1\n",            1, 1, REPLY_OK,        3'b100);
      add_case("LED=3,0\n",            1, 1, REPLY_BAD_INDEX, 3'b100);
      add_case("LED=255,9\n",          1, 1, REPLY_BAD_INDEX, 3'b100);
      add_case("LED=2,2\n",            1, 1, REPLY_BAD_STATE, 3'b100);
      add_case("LED=256,0\n",          0, 0, REPLY_OK,        3'b000);
      add_case("LED=2,257\n",          0, 0, REPLY_OK,        3'b000);
      add_case("LEDx\n",               1, 1, REPLY_BAD_FMT,   3'b001);
      add_case("LED\n",                1, 1, REPLY_BAD_FMT,   3'b001);
      add_case("LED ^=1,0\n",          1, 1, REPLY_BAD_FMT,   3'b001);
      add_case("LED!\n",               1, 1, REPLY_BAD_FMT,   3'b001);
      add_case("LED=1,0^9\n",          0, 0, REPLY_OK,        3'b000);
      add_case("LED=,0\n",             1, 0, REPLY_OK,        3'b000);
      add_case("LED=1 0\n",            1, 0, REPLY_OK,        3'b000);
      add_case("LED=1,\n",             1, 0, REPLY_OK,        3'b000);
      add_case("LEX=1,0\n",            1, 0, REPLY_OK,        3'b000);
      add_case("\n",                   1, 0, REPLY_OK,        3'b000);
      add_case("_LED=0,0\n",           1, 0, REPLY_OK,        3'b000);
      add_case("LED=1~\n",             1, 0, REPLY_OK,        3'b000);
      add_case("LED=0^,1\n",           1, 0, REPLY_OK,        3'b000);
      add_case("LED=00,1 trail~\n",    0, 0, REPLY_OK,        3'b000);

      foreach (line_cases[k]) begin
         load_text(line_cases[k].text);
         send_line($urandom_range(0, 3) == 0, line_cases[k].typed,
                   line_cases[k].replies, line_cases[k].reply);
      end

      while (bytes_sent < ITEM_TARGET) begin
         make_random_line();
         send_line($urandom_range(0, 3) == 0, 1'b0, 1'b0, none);
      end
      req_valid <= 1'b0;

      while (due_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      int beats_seen;
      int w;
      bit calm;
      led_reply_type want;
      beats_seen = 0;
      calm = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTED)
                  $display("unexpected reply beat: code %0d leds %b",
                           rsp_reply_code, rsp_led_levels);
            end else begin
               want = due_replies.pop_front();
               if (rsp_reply_code !== want.code || rsp_led_levels !== want.leds) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTED)
                     $display("reply mismatch: expected code %0d leds %b, got code %0d leds %b",
                              want.code, want.leds, rsp_reply_code, rsp_led_levels);
               end
            end
            beats_seen++;
            if ($urandom_range(0, 15) == 0) calm = !calm;
            // long hold-off at one chosen beat so the input side backs up, else a short random or no stall
            w = (beats_seen == HOLD_AT_BEAT) ? HOLD_CYCLES :
                calm ? 0 : $urandom_range(0, 7);
            if (w > 0) begin
               rsp_stall <= 1'b1;
               repeat (w) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire
